FILE: rtl/bmhq_pkg.sv
// Shared types and codes for the binary min-heap priority queue.
package bmhq_pkg;

	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 16;
	localparam int COUNT_W   = 11;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	typedef struct packed {
		logic                        cmd;
		logic signed [KEY_W-1:0]     key_in;
		logic        [PAYLOAD_W-1:0] payload_in;
	} req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0]     key_out;
		logic        [PAYLOAD_W-1:0] payload_out;
		logic                        popped;
		logic        [1:0]           error_code;
		logic                        is_empty;
		logic        [COUNT_W-1:0]   entry_count;
	} rsp_t;

	// Verdict of the shared key compare unit.
	typedef struct packed {
		logic node_lt_left;  // moving entry strictly below the left/parent key
		logic stop;          // sift-down ends at the current slot
		logic pick_right;    // sift-down promotes the right child
	} cmp_dec_t;

endpackage

FILE: rtl/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmhq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/bmhq_cmp.sv
// Shared signed key compare unit: sift-up test and sift-down child choice.
module bmhq_cmp (
	input  logic signed [bmhq_pkg::KEY_W-1:0] node_key,
	input  logic signed [bmhq_pkg::KEY_W-1:0] left_key,
	input  logic signed [bmhq_pkg::KEY_W-1:0] right_key,
	input  logic                              has_right,
	output bmhq_pkg::cmp_dec_t                dec
);
	import bmhq_pkg::*;

	logic node_lt_left;
	logic node_lt_right;
	logic right_lt_left;

	assign node_lt_left  = node_key < left_key;
	assign node_lt_right = node_key < right_key;
	assign right_lt_left = right_key < left_key;

	// one child: stop only if strictly below it
	// two children: stop only if strictly below both, ties go left
	assign dec.node_lt_left = node_lt_left;
	assign dec.stop         = has_right ? (node_lt_left && node_lt_right) : node_lt_left;
	assign dec.pick_right   = has_right && right_lt_left;

endmodule

FILE: rtl/binary_min_heap_queue.sv
// Top level: binary min-heap priority queue with an iterative sift sequencer.
//
// Usage notes:
// - Request channel (req_valid/req_ready/req): cmd selects push (key_in,
//   payload_in appended) or pop (smallest key removed). Keys are signed and
//   compared alone; payloads ride along.
// - Response channel (rsp_valid/rsp_ready/rsp): exactly one response per
//   request, carrying the popped entry (or zeros), popped flag, error_code,
//   is_empty and entry_count as they stand after the operation.
// - Push on a full heap is dropped with error_code = full; pop on an empty
//   heap reports error_code = empty. Neither changes the heap.
// - A push climbs the heap one level at a time and a pop descends it one
//   level at a time (a pop that empties the heap skips the descent). The
//   single registered read port of the heap RAM paces each step: one heap
//   word is fetched per cycle at most.
// - One transaction in flight: req_ready is high only while the sequencer is
//   idle, the cycle after each response is posted. A finished response waits
//   in an output register; while rsp_ready holds it, the next transaction
//   stalls the sequencer at its result state until the register frees.
// - Reset clears the entry count and the sequencer, not the heap RAM.
module binary_min_heap_queue #(
	parameter int HEAP_DEPTH   = 1024,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bmhq_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output bmhq_pkg::rsp_t   rsp
);
	import bmhq_pkg::*;

	// stored payload bits: the port carries at most PAYLOAD_W of them
	localparam int PB = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
	localparam int EW = KEY_W + PB;                 // heap word: {payload, key}
	localparam int AW = $clog2(HEAP_DEPTH);         // heap slot index
	localparam int SW = $clog2(HEAP_DEPTH + 1);     // entry count
	localparam int CW = AW + 2;                     // child index, may pass the end

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_UP       = 4'd1;  // fetch parent or settle at root
	localparam logic [3:0] S_UP_CMP   = 4'd2;  // compare with parent
	localparam logic [3:0] S_POP_ROOT = 4'd3;  // root word arrives
	localparam logic [3:0] S_POP_LAST = 4'd4;  // last word arrives
	localparam logic [3:0] S_DN       = 4'd5;  // fetch left child or settle
	localparam logic [3:0] S_DN_L     = 4'd6;  // left child arrives
	localparam logic [3:0] S_DN_R     = 4'd7;  // right child arrives
	localparam logic [3:0] S_RESULT   = 4'd8;  // hand response to output reg

	logic [3:0]           state_q;
	logic [SW-1:0]        size_q;
	logic [AW-1:0]        pos_q;      // current hole of the moving entry
	logic [EW-1:0]        cur_q;      // moving entry
	logic [EW-1:0]        left_q;     // left child held while right is fetched
	logic [KEY_W-1:0]     res_key_q;
	logic [PAYLOAD_W-1:0] res_pay_q;
	logic                 res_popped_q;
	logic [1:0]           res_err_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [EW-1:0]        wr_data;
	logic [AW-1:0]        rd_addr;
	logic [EW-1:0]        rd_data;

	logic [CW-1:0]        left_c;
	logic [CW-1:0]        right_c;
	logic [CW-1:0]        size_c;
	logic                 has_right;
	logic [AW-1:0]        pos_m1;
	logic [AW-1:0]        parent;
	logic [EW-1:0]        left_ent;
	logic [EW-1:0]        req_ent;
	logic [31:0]          size_ext;
	logic                 rsp_free;
	cmp_dec_t             dec;

	// index arithmetic
	assign left_c    = CW'({pos_q, 1'b1});
	assign right_c   = left_c + CW'(1);
	assign size_c    = CW'(size_q);
	assign has_right = right_c < size_c;
	assign pos_m1    = pos_q - AW'(1);
	assign parent    = AW'(pos_m1 >> 1);

	assign req_ent  = {req.payload_in[PB-1:0], req.key_in};
	assign left_ent = (state_q == S_DN_R) ? left_q : rd_data;
	assign size_ext = 32'(size_q);
	assign rsp_free = !rsp_valid_q || rsp_ready;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bmhq_ram #(
		.WIDTH (EW),
		.DEPTH (HEAP_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Shared compare unit. In S_UP_CMP the "left" input is the parent; in
	// sift-down it sees the left child (live or held) and the right child.
	bmhq_cmp u_cmp (
		.node_key  (cur_q[KEY_W-1:0]),
		.left_key  (left_ent[KEY_W-1:0]),
		.right_key (rd_data[KEY_W-1:0]),
		.has_right (state_q == S_DN_R),
		.dec       (dec)
	);

	// RAM read address: issued in the state just before the word is consumed
	always_comb begin
		rd_addr = '0;
		case (state_q)
			S_UP:       rd_addr = parent;
			S_POP_ROOT: rd_addr = size_q[AW-1:0];   // last slot after the decrement
			S_DN:       rd_addr = left_c[AW-1:0];
			S_DN_L:     rd_addr = right_c[AW-1:0];
			default:    rd_addr = '0;               // idle fetches the root
		endcase
	end

	// RAM write: either a promoted/demoted neighbor or the moving entry settles
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		case (state_q)
			S_UP: begin
				wr_en = (pos_q == '0);
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (dec.node_lt_left) begin
					wr_data = rd_data;   // parent moves down
				end
			end
			S_DN: begin
				wr_en = (left_c >= size_c);
			end
			S_DN_L: begin
				if (!has_right) begin
					wr_en = 1'b1;
					if (!dec.stop) begin
						wr_data = rd_data;
					end
				end
			end
			S_DN_R: begin
				wr_en = 1'b1;
				if (!dec.stop) begin
					wr_data = dec.pick_right ? rd_data : left_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// payload state: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q     <= req_ent;
				pos_q     <= size_q[AW-1:0];
				res_key_q <= '0;
				res_pay_q <= '0;
			end
			S_UP_CMP: begin
				if (dec.node_lt_left) begin
					pos_q <= parent;
				end
			end
			S_POP_ROOT: begin
				res_key_q <= rd_data[KEY_W-1:0];
				res_pay_q <= PAYLOAD_W'(rd_data[EW-1:KEY_W]);
			end
			S_POP_LAST: begin
				cur_q <= rd_data;
				pos_q <= '0;
			end
			S_DN_L: begin
				left_q <= rd_data;
				if (!has_right) begin
					pos_q <= left_c[AW-1:0];
				end
			end
			S_DN_R: begin
				pos_q <= dec.pick_right ? right_c[AW-1:0] : left_c[AW-1:0];
			end
			S_RESULT: begin
				if (rsp_free) begin
					rsp_q.key_out     <= res_key_q;
					rsp_q.payload_out <= res_pay_q;
					rsp_q.popped      <= res_popped_q;
					rsp_q.error_code  <= res_err_q;
					rsp_q.is_empty    <= (size_q == '0);
					rsp_q.entry_count <= size_ext[COUNT_W-1:0];
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			size_q       <= '0;
			res_popped_q <= 1'b0;
			res_err_q    <= ERR_NONE;
			rsp_valid_q  <= 1'b0;
		end else begin
			// post a finished response, or drop the one just taken
			if (state_q == S_RESULT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						res_popped_q <= 1'b0;
						if (req.cmd == CMD_PUSH) begin
							if (size_q == SW'(HEAP_DEPTH)) begin
								res_err_q <= ERR_FULL;
								state_q   <= S_RESULT;
							end else begin
								res_err_q <= ERR_NONE;
								size_q    <= size_q + SW'(1);
								state_q   <= S_UP;
							end
						end else begin
							if (size_q == '0) begin
								res_err_q <= ERR_EMPTY;
								state_q   <= S_RESULT;
							end else begin
								res_err_q <= ERR_NONE;
								size_q    <= size_q - SW'(1);
								state_q   <= S_POP_ROOT;
							end
						end
					end
				end
				S_UP: begin
					state_q <= (pos_q == '0) ? S_RESULT : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= dec.node_lt_left ? S_UP : S_RESULT;
				end
				S_POP_ROOT: begin
					res_popped_q <= 1'b1;
					state_q      <= (size_q == '0) ? S_RESULT : S_POP_LAST;
				end
				S_POP_LAST: begin
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= (left_c >= size_c) ? S_RESULT : S_DN_L;
				end
				S_DN_L: begin
					if (has_right) begin
						state_q <= S_DN_R;
					end else begin
						state_q <= dec.stop ? S_RESULT : S_DN;
					end
				end
				S_DN_R: begin
					state_q <= dec.stop ? S_RESULT : S_DN;
				end
				S_RESULT: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 100ps

module testbench;
	import bmhq_pkg::*;

	localparam int DEPTH  = 1024;
	localparam int OWED_N = 16;    // ring of owed responses, far above what is in flight

	// One heap slot as the scoreboard keeps it: only the key takes part in compares.
	typedef struct packed {
		logic signed [KEY_W-1:0]     key;
		logic        [PAYLOAD_W-1:0] pl;
	} slot_t;

	// Directed stimulus row. When typed is set, want is the literal response;
	// otherwise the heap model supplies it.
	typedef struct packed {
		req_t op;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	localparam rsp_t NO_RSP = '0;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_ready = 1'b0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	// Scoreboard heap: mirror of the queue contents.
	slot_t heap_mem [DEPTH];
	int    heap_cnt = 0;

	rsp_t  owed_mem [OWED_N];   // responses owed by the DUT, oldest first
	int    owed_wr        = 0;
	int    owed_rd        = 0;
	int    miss_cnt       = 0;
	int    send_idle_pct  = 0;  // chance the request side idles before a transaction
	int    rsp_stall_pct  = 0;  // chance rsp_ready is low in a given cycle

	binary_min_heap_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the DUT hangs on a handshake.
	initial begin
		#(10_000_000);
		$display("binary_min_heap_queue: mismatch");
		$finish;
	end

	// One line per problem, and every one is counted.
	task automatic flag_miss(input string what);
		$display("%0t ERROR %s", $time, what);
		miss_cnt++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			flag_miss($sformatf("%s got %h want %h", name, got, want));
		end
	endtask

	// Apply one operation to the scoreboard heap and return the response it owes.
	// Sift rules match the DUT exactly, so ties between equal keys resolve
	// the same way on both sides.
	function automatic rsp_t heap_apply(input req_t op);
		rsp_t  res;
		slot_t tmp;
		int    pos;
		int    par;
		int    lc;
		int    rc;
		int    pick;
		res = '0;
		if (op.cmd == CMD_PUSH) begin
			if (heap_cnt >= DEPTH) begin
				res.error_code = ERR_FULL;   // dropped, heap untouched
			end else begin
				heap_mem[heap_cnt].key = op.key_in;
				heap_mem[heap_cnt].pl  = op.payload_in;
				pos = heap_cnt;
				heap_cnt++;
				// climb while strictly below the parent
				while (pos > 0) begin
					par = (pos - 1) / 2;
					if (!($signed(heap_mem[pos].key) < $signed(heap_mem[par].key))) break;
					tmp           = heap_mem[pos];
					heap_mem[pos] = heap_mem[par];
					heap_mem[par] = tmp;
					pos           = par;
				end
			end
		end else begin
			if (heap_cnt == 0) begin
				res.error_code = ERR_EMPTY;
			end else begin
				res.key_out     = heap_mem[0].key;
				res.payload_out = heap_mem[0].pl;
				res.popped      = 1'b1;
				heap_cnt--;
				heap_mem[0] = heap_mem[heap_cnt];
				pos = 0;
				while (2 * pos + 1 < heap_cnt) begin
					lc = 2 * pos + 1;
					rc = lc + 1;
					if (rc == heap_cnt) begin
						// lone left child: swap unless strictly below it
						if ($signed(heap_mem[pos].key) < $signed(heap_mem[lc].key)) break;
						pick = lc;
					end else begin
						// two children: stop only if strictly below both;
						// right wins only when strictly below left
						if ($signed(heap_mem[pos].key) < $signed(heap_mem[lc].key) &&
								$signed(heap_mem[pos].key) < $signed(heap_mem[rc].key)) break;
						pick = ($signed(heap_mem[rc].key) < $signed(heap_mem[lc].key)) ? rc : lc;
					end
					tmp            = heap_mem[pos];
					heap_mem[pos]  = heap_mem[pick];
					heap_mem[pick] = tmp;
					pos            = pick;
				end
			end
		end
		res.is_empty    = (heap_cnt == 0);
		res.entry_count = heap_cnt[COUNT_W-1:0];
		return res;
	endfunction

	// Random operation. Keys favor a narrow band so equal keys are common,
	// with full-range values and the extremes mixed in.
	function automatic req_t rand_req(input int push_pct);
		req_t        r;
		logic [31:0] k;
		int          sel;
		sel = $urandom_range(9);
		if (sel < 4) begin
			k = $urandom_range(15) - 8;
		end else if (sel < 8) begin
			k = $urandom;
		end else begin
			case ($urandom_range(3))
				0: k = 32'h8000_0000;
				1: k = 32'h7fff_ffff;
				2: k = 32'hffff_ffff;
				default: k = 32'h0000_0000;
			endcase
		end
		r.cmd        = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
		r.key_in     = k;
		r.payload_in = PAYLOAD_W'($urandom);
		return r;
	endfunction

	// Present one request and wait for the handshake. Valid only drops when
	// an idle gap is taken, so it never falls and rises in the same step.
	task automatic send_txn(input req_t op, input bit typed, input rsp_t want);
		rsp_t pred;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req       <= op;
		do @(posedge clk); while (!req_ready);
		// transaction accepted at this edge
		pred = heap_apply(op);
		if (owed_wr - owed_rd >= OWED_N) begin
			flag_miss("too many responses outstanding");
		end
		owed_mem[owed_wr % OWED_N] = typed ? want : pred;
		owed_wr++;
	endtask

	// Hold off new requests until every owed response has come back.
	task automatic quiesce();
		req_valid <= 1'b0;
		do @(posedge clk); while (owed_wr != owed_rd);
	endtask

	// Response side: check each accepted transaction, then pick the next ready.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_wr == owed_rd) begin
				flag_miss("response with nothing outstanding");
			end else begin
				want = owed_mem[owed_rd % OWED_N];
				owed_rd++;
				cmp_field("key_out",     32'(rsp.key_out),     32'(want.key_out));
				cmp_field("payload_out", 32'(rsp.payload_out), 32'(want.payload_out));
				cmp_field("popped",      32'(rsp.popped),      32'(want.popped));
				cmp_field("error_code",  32'(rsp.error_code),  32'(want.error_code));
				cmp_field("is_empty",    32'(rsp.is_empty),    32'(want.is_empty));
				cmp_field("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
			end
		end
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	initial begin
		dir_row_t dir_tab [20];
		int       send_pct_tab  [4];
		int       stall_pct_tab [4];

		// Directed part: error cases, key extremes, payload bit patterns,
		// and a run of equal keys whose service order follows the sift rules.
		dir_tab = '{
			// pop straight after reset: empty error
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b1,
				{32'h0, 16'h0, 1'b0, ERR_EMPTY, 1'b1, 11'd0} },
			// first push: nothing returned, one entry held
			'{ {CMD_PUSH, 32'h0000_0000, 16'h0000}, 1'b1,
				{32'h0, 16'h0, 1'b0, ERR_NONE, 1'b0, 11'd1} },
			'{ {CMD_PUSH, 32'h7fff_ffff, 16'hffff}, 1'b0, NO_RSP },
			'{ {CMD_PUSH, 32'h8000_0000, 16'h5555}, 1'b0, NO_RSP },
			'{ {CMD_PUSH, 32'hffff_ffff, 16'haaaa}, 1'b0, NO_RSP },
			'{ {CMD_PUSH, 32'h0000_0001, 16'h0001}, 1'b0, NO_RSP },
			// equal keys
			'{ {CMD_PUSH, 32'h0000_0005, 16'h000a}, 1'b0, NO_RSP },
			'{ {CMD_PUSH, 32'h0000_0005, 16'h000b}, 1'b0, NO_RSP },
			'{ {CMD_PUSH, 32'h0000_0005, 16'h000c}, 1'b0, NO_RSP },
			'{ {CMD_PUSH, 32'h0000_0005, 16'h000d}, 1'b0, NO_RSP },
			// most negative key comes out first
			'{ {CMD_POP,  32'hdead_beef, 16'hbeef}, 1'b1,
				{32'h8000_0000, 16'h5555, 1'b1, ERR_NONE, 1'b0, 11'd8} },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b0, NO_RSP },
			// drained again
			'{ {CMD_POP,  32'h0000_0000, 16'h0000}, 1'b1,
				{32'h0, 16'h0, 1'b0, ERR_EMPTY, 1'b1, 11'd0} }
		};
		// random phases: no idling, sender idle, receiver stall, both
		send_pct_tab  = '{0, 67,  0, 13};
		stall_pct_tab = '{0,  0, 67, 13};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			send_txn(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);
		end
		quiesce();

		// Each random phase leans toward pushes first so the heap gets some
		// depth, then toward pops so it drains and hits the empty case.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct_tab[ph];
			rsp_stall_pct = stall_pct_tab[ph];
			for (int i = 0; i < 112; i++) begin
				send_txn(rand_req((i < 56) ? 65 : 35), 1'b0, NO_RSP);
			end
			quiesce();
		end

		// Drain whatever is left, then one more pop must report the empty heap.
		send_idle_pct = 13;
		rsp_stall_pct = 13;
		while (heap_cnt > 0) begin
			send_txn(rand_req(0), 1'b0, NO_RSP);
		end
		send_txn({CMD_POP, 32'h0000_0000, 16'h0000}, 1'b1,
			{32'h0, 16'h0, 1'b0, ERR_EMPTY, 1'b1, 11'd0});

		quiesce();
		// let any stray response show up before the verdict
		repeat (100) @(posedge clk);
		if (owed_wr != owed_rd) begin
			flag_miss($sformatf("%0d responses never arrived", owed_wr - owed_rd));
		end
		if (miss_cnt == 0) begin
			$display("binary_min_heap_queue: match");
		end else begin
			$display("binary_min_heap_queue: mismatch");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_cmp.sv
rtl/binary_min_heap_queue.sv
bench/testbench.sv
